// ===== hdl/cial_pkg.sv =====
// Shared constants and operation codes for the complex integer ALU.
`default_nettype none
package cial_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int CMD_W = 2;
    localparam int RES_W = 33;
    // Passthrough bundle carried alongside the divider: cmd, early results, signs, zero flag.
    localparam int TAG_W = CMD_W + 2 * RES_W + 3;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

    typedef struct packed {
        logic                    zero;
        logic                    neg_im;
        logic                    neg_re;
        logic signed [RES_W-1:0] er_im;
        logic signed [RES_W-1:0] er_re;
        logic [CMD_W-1:0]        cmd;
    } tag_t;
endpackage
`default_nettype wire

// ===== hdl/complex_integer_alu_unit.sv =====
// Complex integer ALU: add, subtract, multiply and divide of complex operands.
//
// Input channel s_*: s_tuser carries the operation (add, subtract, multiply,
// divide), s_tdata the four operand parts. Result channel m_*: m_tdata holds
// the real and imaginary results (33 bits each), m_tuser flags a divide by a
// zero divisor, in which case both results are zero.
// Every request takes the same path: two front stages (products, then sums
// and signs), OPERAND_WIDTH+1 divider stages resolving one quotient bit each,
// and an output register, for every operation. One request is accepted per
// cycle while the receiver keeps up, so throughput is one result per cycle.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles collapse: when the receiver stalls, results
// pile up in the stages and s_tready drops only once every stage is full.
// Nothing is lost or repeated across a stall. Synchronous reset empties all
// stages; there is no other state.
`default_nettype none
module complex_integer_alu_unit #(
    parameter int OPERAND_WIDTH = cial_pkg::OPERAND_WIDTH_DEF
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        s_tvalid,
    output logic                                       s_tready,
    // a_re, a_im, b_re, b_im from bit 0 up, zero padded
    input  wire  [((4*OPERAND_WIDTH+7)/8)*8-1:0]       s_tdata,
    // cmd
    input  wire  [cial_pkg::CMD_W-1:0]                 s_tuser,
    output logic                                       m_tvalid,
    input  wire                                        m_tready,
    // res_re, res_im from bit 0 up, zero padded
    output logic [((2*cial_pkg::RES_W+7)/8)*8-1:0]     m_tdata,
    // div_by_zero
    output logic                                       m_tuser
);
    import cial_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int N     = 2 * W;
    localparam int Q     = W + 1;
    localparam int OUT_W = ((2*RES_W+7)/8)*8;

    logic               st_valid [Q+1];
    logic               st_ready [Q+1];
    tag_t               st_tag   [Q+1];
    logic [N-1:0]       st_rem_re[Q+1];
    logic [N-1:0]       st_rem_im[Q+1];
    logic [N-1:0]       st_den   [Q+1];
    logic [Q-1:0]       st_q_re  [Q+1];
    logic [Q-1:0]       st_q_im  [Q+1];

    cial_front #(.OPERAND_WIDTH(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_a_re   (s_tdata[W-1:0]),
        .in_a_im   (s_tdata[2*W-1:W]),
        .in_b_re   (s_tdata[3*W-1:2*W]),
        .in_b_im   (s_tdata[4*W-1:3*W]),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_tag   (st_tag[0]),
        .out_mag_re(st_rem_re[0]),
        .out_mag_im(st_rem_im[0]),
        .out_den   (st_den[0])
    );
    assign st_q_re[0] = '0;
    assign st_q_im[0] = '0;

    for (genvar k = 0; k < Q; k++) begin : g_div
        cial_dstage #(.OPERAND_WIDTH(W), .BIT(Q-1-k)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_tag    (st_tag[k]),
            .in_rem_re (st_rem_re[k]),
            .in_rem_im (st_rem_im[k]),
            .in_den    (st_den[k]),
            .in_q_re   (st_q_re[k]),
            .in_q_im   (st_q_im[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_tag   (st_tag[k+1]),
            .out_rem_re(st_rem_re[k+1]),
            .out_rem_im(st_rem_im[k+1]),
            .out_den   (st_den[k+1]),
            .out_q_re  (st_q_re[k+1]),
            .out_q_im  (st_q_im[k+1])
        );
    end

    // output register
    logic                    m_valid_reg;
    logic signed [RES_W-1:0] res_re_reg, res_im_reg;
    logic                    dbz_reg;
    logic signed [RES_W-1:0] res_re_next, res_im_next, qre_ext, qim_ext;
    logic                    dbz_next;
    tag_t                    ftag;

    assign ftag        = st_tag[Q];
    assign st_ready[Q] = !m_valid_reg || m_tready;

    always_comb begin
        qre_ext     = RES_W'(st_q_re[Q]);
        qim_ext     = RES_W'(st_q_im[Q]);
        res_re_next = ftag.er_re;
        res_im_next = ftag.er_im;
        dbz_next    = 1'b0;
        if (ftag.cmd == CMD_DIV) begin
            if (ftag.zero) begin
                res_re_next = '0;
                res_im_next = '0;
                dbz_next    = 1'b1;
            end else begin
                res_re_next = ftag.neg_re ? -qre_ext : qre_ext;
                res_im_next = ftag.neg_im ? -qim_ext : qim_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_ready[Q]) begin
            m_valid_reg <= st_valid[Q];
        end
        if (st_ready[Q] && st_valid[Q]) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            dbz_reg    <= dbz_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({res_im_reg, res_re_reg});
    assign m_tuser  = dbz_reg;
endmodule
`default_nettype wire

// ===== hdl/cial_front.sv =====
// Front end: operand products, then sums, signs and squared divisor magnitude.
`default_nettype none
module cial_front #(
    parameter int OPERAND_WIDTH = cial_pkg::OPERAND_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire  [cial_pkg::CMD_W-1:0]           in_cmd,
    input  wire  signed [OPERAND_WIDTH-1:0]      in_a_re,
    input  wire  signed [OPERAND_WIDTH-1:0]      in_a_im,
    input  wire  signed [OPERAND_WIDTH-1:0]      in_b_re,
    input  wire  signed [OPERAND_WIDTH-1:0]      in_b_im,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output cial_pkg::tag_t                       out_tag,
    output logic [2*OPERAND_WIDTH-1:0]           out_mag_re,
    output logic [2*OPERAND_WIDTH-1:0]           out_mag_im,
    output logic [2*OPERAND_WIDTH-1:0]           out_den
);
    import cial_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam int P = 2 * W;

    // stage A: products and add/sub
    logic                    va_reg;
    logic [CMD_W-1:0]        cmd_a_reg;
    logic signed [P-1:0]     p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [RES_W-1:0] as_re_reg, as_im_reg;
    logic                    ready_a;

    // stage B
    logic                    vb_reg;
    tag_t                    tag_b_reg;
    logic [P-1:0]            mag_re_reg, mag_im_reg, den_reg;
    logic                    ready_b;

    logic signed [W:0]       as_re_next, as_im_next;
    logic signed [P:0]       mul_re, mul_im, num_re, num_im;
    logic signed [P:0]       abs_re, abs_im;
    logic [P:0]              den_sum;
    tag_t                    tag_next;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb begin
        if (in_cmd == CMD_SUB) begin
            as_re_next = (W+1)'(in_a_re) - (W+1)'(in_b_re);
            as_im_next = (W+1)'(in_a_im) - (W+1)'(in_b_im);
        end else begin
            as_re_next = (W+1)'(in_a_re) + (W+1)'(in_b_re);
            as_im_next = (W+1)'(in_a_im) + (W+1)'(in_b_im);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ready_a) begin
            va_reg <= in_valid;
        end
        if (ready_a && in_valid) begin
            cmd_a_reg <= in_cmd;
            p_rr_reg  <= P'(in_a_re) * P'(in_b_re);
            p_ii_reg  <= P'(in_a_im) * P'(in_b_im);
            p_ri_reg  <= P'(in_a_re) * P'(in_b_im);
            p_ir_reg  <= P'(in_a_im) * P'(in_b_re);
            p_bb_reg  <= P'(in_b_re) * P'(in_b_re);
            p_cc_reg  <= P'(in_b_im) * P'(in_b_im);
            as_re_reg <= RES_W'(as_re_next);
            as_im_reg <= RES_W'(as_im_next);
        end
    end

    always_comb begin
        mul_re  = (P+1)'(p_rr_reg) - (P+1)'(p_ii_reg);
        mul_im  = (P+1)'(p_ri_reg) + (P+1)'(p_ir_reg);
        num_re  = (P+1)'(p_rr_reg) + (P+1)'(p_ii_reg);
        num_im  = (P+1)'(p_ir_reg) - (P+1)'(p_ri_reg);
        den_sum = (P+1)'(unsigned'(p_bb_reg)) + (P+1)'(unsigned'(p_cc_reg));
        abs_re  = num_re[P] ? -num_re : num_re;
        abs_im  = num_im[P] ? -num_im : num_im;

        tag_next.cmd    = cmd_a_reg;
        tag_next.zero   = (den_sum == '0);
        tag_next.neg_re = num_re[P];
        tag_next.neg_im = num_im[P];
        if (cmd_a_reg == CMD_MUL) begin
            tag_next.er_re = RES_W'(mul_re);
            tag_next.er_im = RES_W'(mul_im);
        end else begin
            tag_next.er_re = as_re_reg;
            tag_next.er_im = as_im_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ready_b) begin
            vb_reg <= va_reg;
        end
        if (ready_b && va_reg) begin
            tag_b_reg  <= tag_next;
            mag_re_reg <= abs_re[P-1:0];
            mag_im_reg <= abs_im[P-1:0];
            den_reg    <= den_sum[P-1:0];
        end
    end

    assign out_valid  = vb_reg;
    assign out_tag    = tag_b_reg;
    assign out_mag_re = mag_re_reg;
    assign out_mag_im = mag_im_reg;
    assign out_den    = den_reg;
endmodule
`default_nettype wire

// ===== hdl/cial_dstage.sv =====
// One restoring-division stage: resolves one quotient bit for both parts.
`default_nettype none
module cial_dstage #(
    parameter int OPERAND_WIDTH = cial_pkg::OPERAND_WIDTH_DEF,
    parameter int BIT           = 0
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  cial_pkg::tag_t             in_tag,
    input  wire  [2*OPERAND_WIDTH-1:0]       in_rem_re,
    input  wire  [2*OPERAND_WIDTH-1:0]       in_rem_im,
    input  wire  [2*OPERAND_WIDTH-1:0]       in_den,
    input  wire  [OPERAND_WIDTH:0]           in_q_re,
    input  wire  [OPERAND_WIDTH:0]           in_q_im,
    output logic                             out_valid,
    input  wire                              out_ready,
    output cial_pkg::tag_t                   out_tag,
    output logic [2*OPERAND_WIDTH-1:0]       out_rem_re,
    output logic [2*OPERAND_WIDTH-1:0]       out_rem_im,
    output logic [2*OPERAND_WIDTH-1:0]       out_den,
    output logic [OPERAND_WIDTH:0]           out_q_re,
    output logic [OPERAND_WIDTH:0]           out_q_im
);
    import cial_pkg::*;

    localparam int N = 2 * OPERAND_WIDTH;
    localparam int Q = OPERAND_WIDTH + 1;
    localparam int E = N + Q;

    logic         v_reg;
    tag_t         tag_reg;
    logic [N-1:0] rem_re_reg, rem_im_reg, den_reg;
    logic [Q-1:0] q_re_reg, q_im_reg;

    logic [E-1:0] dsh, diff_re, diff_im;
    logic         ge_re, ge_im;
    logic [N-1:0] rem_re_next, rem_im_next;
    logic [Q-1:0] q_re_next, q_im_next;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        dsh       = E'(in_den) << BIT;
        ge_re     = E'(in_rem_re) >= dsh;
        ge_im     = E'(in_rem_im) >= dsh;
        diff_re   = E'(in_rem_re) - dsh;
        diff_im   = E'(in_rem_im) - dsh;
        rem_re_next = ge_re ? diff_re[N-1:0] : in_rem_re;
        rem_im_next = ge_im ? diff_im[N-1:0] : in_rem_im;
        q_re_next = in_q_re;
        q_im_next = in_q_im;
        q_re_next[BIT] = ge_re;
        q_im_next[BIT] = ge_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            tag_reg    <= in_tag;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            den_reg    <= in_den;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
        end
    end

    assign out_valid  = v_reg;
    assign out_tag    = tag_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_den    = den_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;
endmodule
`default_nettype wire

// ===== hdl/cial_checker.sv =====
// Port-level checker for the complex integer ALU, bound to the top level.
`default_nettype none
module cial_checker #(
    parameter int OPERAND_WIDTH = cial_pkg::OPERAND_WIDTH_DEF
) (
    input wire                                        aclk,
    input wire                                        aresetn,
    input wire                                        s_tvalid,
    input wire                                        s_tready,
    input wire [((4*OPERAND_WIDTH+7)/8)*8-1:0]        s_tdata,
    input wire [cial_pkg::CMD_W-1:0]                  s_tuser,
    input wire                                        m_tvalid,
    input wire                                        m_tready,
    input wire [((2*cial_pkg::RES_W+7)/8)*8-1:0]      m_tdata,
    input wire                                        m_tuser
);
    import cial_pkg::*;

    // results leave reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // zero-divisor flag forces zero results
    a_dbz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("div_by_zero with nonzero result");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a waiting request stays put until taken
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while waiting");
endmodule

bind complex_integer_alu_unit cial_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_cial_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
`default_nettype wire

// ===== dv/complex_integer_alu_unit_tb.sv =====
// Self-checking testbench for the complex integer ALU stream unit.
`default_nettype none
module complex_integer_alu_unit_tb;
    import cial_pkg::*;

    localparam int OW = OPERAND_WIDTH_DEF;
    localparam int SDW = ((4*OW+7)/8)*8;
    localparam int MDW = ((2*RES_W+7)/8)*8;
    localparam int LATENCY = OW + 4;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic [RES_W-1:0] re;
        logic [RES_W-1:0] im;
        logic             dbz;
    } cplx_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SDW-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = CMD_ADD;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MDW-1:0] m_tdata;
    logic m_tuser;

    cplx_result_t results_due[$];
    int n_errors = 0;
    int n_checked = 0;
    int n_div_zero = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int idle_cycles = 0;
    int op_count[4] = '{0, 0, 0, 0};

    always #2 aclk = ~aclk;

    complex_integer_alu_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // truncating quotient of num/den, den > 0
    function automatic logic [RES_W-1:0] trunc_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        if (num < 0)
            q = -q;
        return q[RES_W-1:0];
    endfunction

    function automatic cplx_result_t complex_op(logic [CMD_W-1:0] cmd,
            logic signed [OW-1:0] ar, logic signed [OW-1:0] ai,
            logic signed [OW-1:0] br, logic signed [OW-1:0] bi);
        cplx_result_t r;
        longint xr, xi, yr, yi, den, t;
        xr = ar; xi = ai; yr = br; yi = bi;
        r.dbz = 1'b0;
        r.re = '0;
        r.im = '0;
        case (cmd)
            CMD_ADD: begin
                t = xr + yr; r.re = t[RES_W-1:0];
                t = xi + yi; r.im = t[RES_W-1:0];
            end
            CMD_SUB: begin
                t = xr - yr; r.re = t[RES_W-1:0];
                t = xi - yi; r.im = t[RES_W-1:0];
            end
            CMD_MUL: begin
                t = xr * yr - xi * yi; r.re = t[RES_W-1:0];
                t = xr * yi + xi * yr; r.im = t[RES_W-1:0];
            end
            default: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.dbz = 1'b1;
                end else begin
                    r.re = trunc_div(xr * yr + xi * yi, den);
                    r.im = trunc_div(xi * yr - xr * yi, den);
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [OW-1:0] ar,
            logic [OW-1:0] ai, logic [OW-1:0] br, logic [OW-1:0] bi);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= SDW'({bi, br, ai, ar});
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(complex_op(cmd, ar, ai, br, bi));
        op_count[cmd]++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() > 0)
            @(posedge aclk);
    endtask

    function automatic logic [OW-1:0] rand_operand();
        case ($urandom_range(5))
            0: return {1'b0, {(OW-1){1'b1}}};
            1: return {1'b1, {(OW-1){1'b0}}};
            2: return OW'($urandom_range(3)) - OW'(1);
            3: return OW'($urandom_range(31)) - OW'(16);
            default: return OW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [OW-1:0] mx, mn;
        mx = {1'b0, {(OW-1){1'b1}}};
        mn = {1'b1, {(OW-1){1'b0}}};
        for (int c = 0; c < 4; c++) begin
            send_request(CMD_W'(c), mx, mx, mx, mx);
            send_request(CMD_W'(c), mn, mn, mn, mn);
            send_request(CMD_W'(c), mx, mn, mn, mx);
            send_request(CMD_W'(c), 16'd7, -16'sd9, 16'd2, 16'd3);
        end
        // zero divisor, with zero and nonzero dividends, then nonzero divisors and a multiply
        send_request(CMD_DIV, 16'd5, -16'sd5, 16'd0, 16'd0);
        send_request(CMD_DIV, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(CMD_DIV, mn, mx, 16'd1, 16'd0);
        send_request(CMD_DIV, -16'sd7, 16'd0, 16'd2, 16'd0);
        send_request(CMD_DIV, 16'd1, 16'd1, mn, mn);
        send_request(CMD_MUL, mn, mn, mn, mx);
        drain();
    endtask

    task automatic test_random(int n_items);
        logic [CMD_W-1:0] cmd;
        logic [OW-1:0] br, bi;
        for (int i = 0; i < n_items; i++) begin
            cmd = CMD_W'($urandom_range(3));
            br = rand_operand();
            bi = rand_operand();
            if (cmd == CMD_DIV && $urandom_range(15) == 0) begin
                br = '0;
                bi = '0;
            end
            send_request(cmd, rand_operand(), rand_operand(), br, bi);
        end
        drain();
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_off = 200;
        test_random(60);
    endtask

    // result checker
    always @(posedge aclk) begin
        cplx_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result re=%h im=%h dbz=%b",
                             m_tdata[RES_W-1:0], m_tdata[2*RES_W-1:RES_W], m_tuser);
            end else begin
                exp_r = results_due.pop_front();
                n_checked++;
                if (exp_r.dbz)
                    n_div_zero++;
                if (m_tdata[RES_W-1:0] !== exp_r.re || m_tdata[2*RES_W-1:RES_W] !== exp_r.im
                        || m_tuser !== exp_r.dbz) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp re=%h im=%h dbz=%b got re=%h im=%h dbz=%b",
                                 exp_r.re, exp_r.im, exp_r.dbz, m_tdata[RES_W-1:0],
                                 m_tdata[2*RES_W-1:RES_W], m_tuser);
                end
            end
        end
    end

    // receiver ready, with random idling and long hold-off
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("complex_integer_alu_unit_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 14;
        recv_idle_pct = 82;
        test_directed();
        test_random(400);
        send_idle_pct = 82;
        recv_idle_pct = 14;
        test_random(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(350);
        repeat (LATENCY * 4) @(posedge aclk);
        $display("checked %0d results: add %0d, sub %0d, mul %0d, div %0d (%0d by zero)",
                 n_checked, op_count[0], op_count[1], op_count[2], op_count[3], n_div_zero);
        $display("covered three idling mixes and a long output stall; %0d errors", n_errors);
        if (n_errors == 0 && results_due.size() == 0)
            $display("complex_integer_alu_unit_tb passed");
        else
            $display("complex_integer_alu_unit_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
